// ===== design/iirl_pkg.sv =====
// shared types and constants for the indexed insert/remove list store
`timescale 1ns / 1ps
`default_nettype none

package iirl_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 64;
  localparam int unsigned ELEM_WIDTH_DEFAULT = 32;
  localparam int unsigned DATA_W             = 32;
  localparam int unsigned CNT_W_DEFAULT      = $clog2(DEPTH_DEFAULT + 1);

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_TOP    = 3'd2,
    OP_GET    = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT_UP,
    S_FILL,
    S_SHIFT_DN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== design/iirl_if.sv =====
// request and response channel interfaces of the list store
`timescale 1ns / 1ps
`default_nettype none

interface iirl_req_if #(
  parameter int unsigned CNT_W = iirl_pkg::CNT_W_DEFAULT
);
  import iirl_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [CNT_W-1:0]  position;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output opcode, output position, output data_in, input ready);
  modport sink   (input valid, input opcode, input position, input data_in, output ready);
endinterface

interface iirl_rsp_if #(
  parameter int unsigned CNT_W = iirl_pkg::CNT_W_DEFAULT
);
  import iirl_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [1:0]        status;
  logic [CNT_W-1:0]  entry_count;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, output read_data, output status, output entry_count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input read_data, input status, input entry_count,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== design/iirl_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module iirl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/indexed_insert_remove_list.sv =====
// top level: packed list store with indexed insert and remove over one entry ram
`timescale 1ns / 1ps
`default_nettype none

// push, pop, rejected ops and top on empty go straight from idle to done; top and get
// pass through a read state; insert at p shifts entries p..n-1 up, then fills p; remove at p
// shifts entries p+1..n-1 down; the ram moves one entry per cycle during a shift
// one transaction in work at a time; the next is taken once the result is registered
// reset: list empty, control and output valid cleared; entry ram is not cleared

module indexed_insert_remove_list #(
  parameter int unsigned DEPTH      = iirl_pkg::DEPTH_DEFAULT,
  parameter int unsigned ELEM_WIDTH = iirl_pkg::ELEM_WIDTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iirl_req_if.sink   in_i,
  iirl_rsp_if.source out_o
);

  import iirl_pkg::*;

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  // control state
  state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] idx_q, idx_d;     // entry currently being read during a shift

  // per-transaction payload
  logic [AddrW-1:0]      pos_q, pos_d;
  logic [ELEM_WIDTH-1:0] din_q, din_d;
  logic [DATA_W-1:0]     rd_q, rd_d;
  status_e               st_q, st_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  status_e           out_st_q;
  logic [CntW-1:0]   out_cnt_q;
  logic              out_empty_q;
  logic              out_full_q;
  logic              out_load;

  // ram port controls
  logic                  we;
  logic [AddrW-1:0]      waddr;
  logic [ELEM_WIDTH-1:0] wdata;
  logic                  re;
  logic [AddrW-1:0]      raddr;
  logic [ELEM_WIDTH-1:0] rdata;

  // decode of the incoming transaction
  logic                  accept;
  logic [CntW-1:0]       pos_in;
  logic [ELEM_WIDTH-1:0] din_in;
  logic                  is_full_now;
  logic                  is_empty_now;
  logic                  go_read;
  logic                  go_up;
  logic                  go_dn;
  logic                  up_last;
  logic                  dn_last;

  assign accept       = in_i.valid && in_i.ready;
  assign pos_in       = CntW'(in_i.position);
  assign din_in       = ELEM_WIDTH'(in_i.data_in);   // data outside the element width is dropped
  assign is_full_now  = (count_q == DepthC);
  assign is_empty_now = (count_q == '0);

  // shift up ends once the entry at the insert position has been read
  assign up_last = (idx_q == pos_q);
  // shift down ends at the old last entry, whose index equals the shortened count
  assign dn_last = (idx_q == AddrW'(count_q));

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  iirl_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // datapath, ram controls and handshake
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    din_d       = din_q;
    rd_d        = rd_q;
    st_d        = st_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rdata;
    re          = 1'b0;
    raddr       = '0;
    go_read     = 1'b0;
    go_up       = 1'b0;
    go_dn       = 1'b0;
    in_i.ready  = (state_q == S_IDLE);
    out_valid_d = out_valid_q;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d = AddrW'(pos_in);
          din_d = din_in;
          rd_d  = '0;
          st_d  = ST_OK;
          unique case (op_e'(in_i.opcode))
            OP_PUSH: begin
              if (is_full_now) begin
                st_d = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = AddrW'(count_q);
                wdata   = din_in;
                count_d = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (is_empty_now) begin
                st_d = ST_RANGE;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            OP_TOP: begin
              if (is_empty_now) begin
                st_d = ST_RANGE;
              end else begin
                re      = 1'b1;
                raddr   = AddrW'(count_q - 1'b1);
                go_read = 1'b1;
              end
            end
            OP_GET: begin
              if (pos_in >= count_q) begin
                st_d = ST_RANGE;
              end else begin
                re      = 1'b1;
                raddr   = AddrW'(pos_in);
                go_read = 1'b1;
              end
            end
            OP_INSERT: begin
              // range check wins over the full check
              if (pos_in > count_q) begin
                st_d = ST_RANGE;
              end else if (is_full_now) begin
                st_d = ST_FULL;
              end else begin
                count_d = count_q + 1'b1;
                if (pos_in == count_q) begin
                  // insert at the end is a push
                  we    = 1'b1;
                  waddr = AddrW'(count_q);
                  wdata = din_in;
                end else begin
                  // start moving entries up from the top of the list
                  re    = 1'b1;
                  raddr = AddrW'(count_q - 1'b1);
                  idx_d = AddrW'(count_q - 1'b1);
                  go_up = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (pos_in >= count_q) begin
                st_d = ST_RANGE;
              end else begin
                count_d = count_q - 1'b1;
                // removing the last entry moves nothing
                if (pos_in != count_q - 1'b1) begin
                  re    = 1'b1;
                  raddr = AddrW'(pos_in + 1'b1);
                  idx_d = AddrW'(pos_in + 1'b1);
                  go_dn = 1'b1;
                end
              end
            end
            default: begin
              // undefined opcodes leave everything as is
            end
          endcase
        end
      end
      S_READ: begin
        rd_d = DATA_W'(rdata);
      end
      S_SHIFT_UP: begin
        // read and write addresses never meet: write idx+1, read idx-1
        we    = 1'b1;
        waddr = idx_q + 1'b1;
        wdata = rdata;
        if (!up_last) begin
          re    = 1'b1;
          raddr = idx_q - 1'b1;
          idx_d = idx_q - 1'b1;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = din_q;
      end
      S_SHIFT_DN: begin
        // write idx-1, read idx+1
        we    = 1'b1;
        waddr = idx_q - 1'b1;
        wdata = rdata;
        if (!dn_last) begin
          re    = 1'b1;
          raddr = idx_q + 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        // result waits here until the output register is free
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (go_read) begin
            state_d = S_READ;
          end else if (go_up) begin
            state_d = S_SHIFT_UP;
          end else if (go_dn) begin
            state_d = S_SHIFT_DN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_SHIFT_UP: begin
        if (up_last) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        state_d = S_DONE;
      end
      S_SHIFT_DN: begin
        if (dn_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    din_q <= din_d;
    rd_q  <= rd_d;
    st_q  <= st_d;
    if (out_load) begin
      out_data_q  <= rd_q;
      out_st_q    <= st_q;
      out_cnt_q   <= count_q;
      out_empty_q <= is_empty_now;
      out_full_q  <= is_full_now;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_data_q;
  assign out_o.status      = out_st_q;
  assign out_o.entry_count = out_cnt_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_full_q;

  // the list never grows past its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  // the count only moves when a transaction is taken
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (count_q == $past(count_q)))
    else $error("entry count changed during a transaction");

  // the upward shift never passes the insert position
  a_shift_up_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_UP) |-> (idx_q >= pos_q))
    else $error("shift index below insert position");

  // a full status is only reported on a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_FULL)) |-> out_o.is_full)
    else $error("full status reported on a list that is not full");

endmodule

`default_nettype wire

// ===== tb/indexed_insert_remove_list_tb.sv =====
// self-checking testbench for the indexed insert/remove list store
`timescale 1ns / 1ps

module indexed_insert_remove_list_tb;
  import iirl_pkg::*;

  localparam int unsigned LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int unsigned STIM_TARGET  = 1575;
  localparam int unsigned MAX_REPORTED = 10;
  localparam int unsigned MAX_POS      = 127;

  // opcodes the store leaves undefined; it answers them with an ok status
  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } list_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  iirl_req_if list_req ();
  iirl_rsp_if list_rsp ();

  indexed_insert_remove_list #(
    .DEPTH      (LIST_DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH_DEFAULT)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (list_req),
    .out_o  (list_rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted list contents and fill level, advanced once per accepted transaction
  logic [31:0]  list_model [LIST_DEPTH];
  int unsigned  list_len = 0;
  list_reply_t  pending_replies [$];

  int unsigned error_count   = 0;
  int unsigned checked_count = 0;
  int unsigned sent_count    = 0;
  int unsigned full_rejects  = 0;
  int unsigned range_rejects = 0;
  int unsigned full_reached  = 0;
  int unsigned op_counts [8] = '{default: 0};

  int unsigned burst_left  = 1;
  int unsigned ready_left  = 0;
  logic        ready_level = 1'b1;

  // expected reply of one operation; updates the predicted list as a side effect
  function automatic list_reply_t apply_list_op(input logic [2:0] op, input logic [6:0] pos,
                                                input logic [31:0] din);
    list_reply_t r;
    int unsigned p;
    r = '0;
    r.status = ST_OK;
    p = pos;
    case (op)
      OP_PUSH: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          list_model[list_len] = din;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) r.status = ST_RANGE;
        else list_len--;
      end
      OP_TOP: begin
        if (list_len == 0) r.status = ST_RANGE;
        else r.read_data = list_model[list_len - 1];
      end
      OP_GET: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.read_data = list_model[p];
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (p > list_len) r.status = ST_RANGE;
        else if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          for (int unsigned i = list_len; i > p; i--) list_model[i] = list_model[i - 1];
          list_model[p] = din;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (p >= list_len) r.status = ST_RANGE;
        else begin
          for (int unsigned i = p; i + 1 < list_len; i++) list_model[i] = list_model[i + 1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(list_len);
    r.is_empty    = (list_len == 0);
    r.is_full     = (list_len >= LIST_DEPTH);
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // position in 0..hi, leaning on both ends
  function automatic logic [6:0] near_pos(input int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'(hi);
      default: return 7'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [6:0] any_pos();
    return 7'($urandom_range(0, MAX_POS));
  endfunction

  // one request transaction; the sender runs in bursts with random idle gaps
  task automatic send_op(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] din);
    list_reply_t r;
    int unsigned gap;
    list_req.valid    <= 1'b1;
    list_req.opcode   <= op;
    list_req.position <= pos;
    list_req.data_in  <= din;
    @(posedge clk_i);
    while (!list_req.ready) @(posedge clk_i);
    r = apply_list_op(op, pos, din);
    pending_replies.push_back(r);
    sent_count++;
    op_counts[op]++;
    if (r.status == ST_FULL) full_rejects++;
    if (r.status == ST_RANGE) range_rejects++;
    if (r.is_full && r.status == ST_OK && (op == OP_PUSH || op == OP_INSERT)) full_reached++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        list_req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // empty store, range edges, insert at the end, undefined opcodes
  task automatic test_empty_and_edges();
    send_op(OP_POP,     7'd0,   32'h0);
    send_op(OP_TOP,     7'd0,   32'h0);
    send_op(OP_GET,     7'd0,   32'h0);
    send_op(OP_REMOVE,  7'd0,   32'h0);
    send_op(OP_INSERT,  7'd1,   32'h1234_5678);
    send_op(OP_UNDEF_A, 7'd127, 32'hFFFF_FFFF);
    send_op(OP_UNDEF_B, 7'd64,  32'hDEAD_BEEF);
    send_op(OP_INSERT,  7'd0,   32'hFFFF_FFFF);
    send_op(OP_PUSH,    7'd127, 32'h0000_0000);
    send_op(OP_TOP,     7'd0,   32'h0);
    send_op(OP_GET,     7'd0,   32'h0);
    send_op(OP_GET,     7'd2,   32'h0);
    send_op(OP_GET,     7'd127, 32'h0);
    send_op(OP_INSERT,  7'd127, 32'h0F0F_0F0F);
    send_op(OP_INSERT,  7'd2,   32'hA5A5_5A5A);
    send_op(OP_INSERT,  7'd0,   32'h5A5A_A5A5);
    send_op(OP_GET,     7'd0,   32'h0);
    send_op(OP_GET,     7'd3,   32'h0);
    send_op(OP_REMOVE,  7'd4,   32'h0);
    send_op(OP_REMOVE,  7'd1,   32'h0);
    send_op(OP_REMOVE,  7'd2,   32'h0);
    send_op(OP_REMOVE,  7'd0,   32'h0);
    send_op(OP_POP,     7'd0,   32'h0);
    send_op(OP_POP,     7'd0,   32'h0);
    send_op(OP_TOP,     7'd0,   32'h0);
  endtask

  // grow to full with pushes and inserts, hit the full rejects, then drain
  task automatic test_fill_and_drain(input int unsigned rounds);
    int unsigned pick;
    repeat (rounds) begin
      while (list_len < LIST_DEPTH) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) send_op(OP_PUSH, any_pos(), rand_word());
        else if (pick < 85) send_op(OP_INSERT, near_pos(list_len), rand_word());
        else if (pick < 93 && list_len > 0) send_op(OP_GET, near_pos(list_len - 1), rand_word());
        else send_op(OP_TOP, any_pos(), rand_word());
      end
      send_op(OP_PUSH,   any_pos(), rand_word());
      send_op(OP_INSERT, near_pos(LIST_DEPTH), rand_word());
      send_op(OP_INSERT, 7'(LIST_DEPTH), rand_word());
      send_op(OP_INSERT, 7'($urandom_range(LIST_DEPTH + 1, MAX_POS)), rand_word());
      send_op(OP_GET,    7'(LIST_DEPTH - 1), rand_word());
      send_op(OP_TOP,    any_pos(), rand_word());
      while (list_len > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) send_op(OP_POP, any_pos(), rand_word());
        else if (pick < 85) send_op(OP_REMOVE, near_pos(list_len - 1), rand_word());
        else if (pick < 95) send_op(OP_GET, near_pos(list_len - 1), rand_word());
        else send_op(OP_TOP, any_pos(), rand_word());
      end
      send_op(OP_REMOVE, near_pos(3), rand_word());
      send_op(OP_POP,    any_pos(), rand_word());
    end
  endtask

  // mixed traffic with the fill level drifting, plus a little raw noise
  task automatic test_random_mix();
    int unsigned roll;
    int unsigned grow_pct;
    while (sent_count < STIM_TARGET) begin
      roll = $urandom_range(0, 99);
      grow_pct = (list_len < 12) ? 55 : (list_len > 52) ? 20 : 35;
      if (roll < 4) begin
        send_op(3'($urandom_range(0, 7)), any_pos(), $urandom());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < grow_pct) begin
          if ($urandom_range(0, 1)) send_op(OP_PUSH, any_pos(), rand_word());
          else send_op(OP_INSERT, near_pos(list_len), rand_word());
        end else if (roll < grow_pct + 35) begin
          if ($urandom_range(0, 1)) send_op(OP_POP, any_pos(), rand_word());
          else send_op(OP_REMOVE, (list_len > 0) ? near_pos(list_len - 1) : any_pos(),
                       rand_word());
        end else begin
          if ($urandom_range(0, 2) == 0) send_op(OP_TOP, any_pos(), rand_word());
          else send_op(OP_GET, (list_len > 0) ? near_pos(list_len - 1) : any_pos(),
                       rand_word());
        end
      end
    end
  endtask

  // result side: ready toggles between short runs, short stalls and long open stretches
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_level = !ready_level;
      if (ready_level) ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 160)
                                                                : $urandom_range(1, 6);
      else ready_left = $urandom_range(1, 12);
    end
    ready_left--;
    list_rsp.ready <= ready_level;
  end

  // compare every result transaction with the oldest prediction
  always @(posedge clk_i) begin : reply_check
    list_reply_t got;
    list_reply_t want;
    if (rst_ni && list_rsp.valid && list_rsp.ready) begin
      got.read_data   = list_rsp.read_data;
      got.status      = list_rsp.status;
      got.entry_count = list_rsp.entry_count;
      got.is_empty    = list_rsp.is_empty;
      got.is_full     = list_rsp.is_full;
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTED)
          $display("%0t: result with nothing outstanding: data %h status %0d count %0d",
                   $realtime, got.read_data, got.status, got.entry_count);
      end else begin
        want = pending_replies.pop_front();
        checked_count++;
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTED) begin
            $display("%0t: mismatch on result %0d", $realtime, checked_count);
            $display("  expected data %h status %0d count %0d empty %b full %b",
                     want.read_data, want.status, want.entry_count, want.is_empty,
                     want.is_full);
            $display("  actual   data %h status %0d count %0d empty %b full %b",
                     got.read_data, got.status, got.entry_count, got.is_empty, got.is_full);
          end
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    list_req.valid    = 1'b0;
    list_req.opcode   = OP_PUSH;
    list_req.position = '0;
    list_req.data_in  = '0;
    list_rsp.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_edges();
    test_fill_and_drain(3);
    test_random_mix();

    list_req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    // catch any stray result
    repeat (100) @(posedge clk_i);

    $display("covered %0d transactions (%0d checked): push %0d pop %0d top %0d get %0d",
             sent_count, checked_count, op_counts[OP_PUSH], op_counts[OP_POP],
             op_counts[OP_TOP], op_counts[OP_GET]);
    $display("insert %0d remove %0d undefined %0d; %0d full rejects, %0d range rejects, %0d fills",
             op_counts[OP_INSERT], op_counts[OP_REMOVE],
             op_counts[OP_UNDEF_A] + op_counts[OP_UNDEF_B], full_rejects, range_rejects,
             full_reached);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== indexed_insert_remove_list.f =====
design/iirl_pkg.sv
design/iirl_if.sv
design/iirl_ram.sv
design/indexed_insert_remove_list.sv
tb/indexed_insert_remove_list_tb.sv
